[rtl/three_class_dedup_bucket_sort_unit_assert.svh]
// assertion macros for the bucket sort unit
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef THREE_CLASS_DEDUP_BUCKET_SORT_UNIT_ASSERT_SVH
`define THREE_CLASS_DEDUP_BUCKET_SORT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define TCDBS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

`define TCDBS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");

`else

`define TCDBS_ASSERT(lbl, clk, rst, prop)

`define TCDBS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/tcdbs_pkg.sv]
// shared types, sizes and codes for the bucket sort unit
// no dependencies
package tcdbs_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ID_W     = 32;
   localparam int CLS_W    = 2;
   localparam int BATCH_W  = 6;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 3;

   localparam logic [CLS_W-1:0] CLS_CRITICAL = 2'd0;
   localparam logic [CLS_W-1:0] CLS_SERIOUS  = 2'd1;
   localparam logic [CLS_W-1:0] CLS_STABLE   = 2'd2;
   localparam logic [CLS_W-1:0] CLS_INVALID  = 2'd3;

   localparam logic REG_BATCH_SIZE = 1'b0;

   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_DUP     = 2'd1,
      KIND_INVALID = 2'd2,
      KIND_LIST    = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [ID_W-1:0] id;
      logic [CLS_W-1:0]       cls;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage

[rtl/tcdbs_if.sv]
// word channels of the bucket sort unit: entry in, status or listing out
// depends on tcdbs_pkg
interface tcdbs_req_if;
   import tcdbs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [ID_W-1:0] patient_id;
   logic [CLS_W-1:0]       severity;

   modport source (output valid, output patient_id, output severity, input ready);
   modport sink (input valid, input patient_id, input severity, output ready);
endinterface

interface tcdbs_rsp_if;
   import tcdbs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic signed [ID_W-1:0] out_id;
   logic [CLS_W-1:0]       out_class;
   logic                   last;

   modport source (output valid, output kind, output out_id, output out_class,
                   output last, input ready);
   modport sink (input valid, input kind, input out_id, input out_class,
                 input last, output ready);
endinterface

[rtl/three_class_dedup_bucket_sort_unit.sv]
// three-class bucket sort with duplicate rejection, top level
// status word: for an invalid class the take goes straight to the status state; otherwise a scan
// reads the n stored entries and appends the new one (a duplicate at entry k ends the scan first)
// listing: up to 3 class passes over the stored entries (critical, serious, stable), each in storage order
// next entry is taken once the last word of the previous one is in the output register
// synchronous active-high reset empties the store and sets batch size to 1; no clearing pass
module three_class_dedup_bucket_sort_unit (
   input  logic                          clock,
   input  logic                          reset,
   tcdbs_req_if.sink                     req_port,
   tcdbs_rsp_if.source                   rsp_port,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tcdbs_pkg::ADDR_W-1:0]  paddr,
   input  logic [tcdbs_pkg::DATA_W-1:0]  pwdata,
   output logic [tcdbs_pkg::DATA_W-1:0]  prdata,
   output logic                          pready
);
   import tcdbs_pkg::*;

   logic [BATCH_W-1:0] batch_size;
   mem_req_type        mem_req;
   entry_type          mem_rdata;
   logic [ENTRY_W-1:0] ram_rdata;

   tcdbs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .batch_size (batch_size)
   );

   tcdbs_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (ram_rdata)
   );

   assign mem_rdata = entry_type'(ram_rdata);

   tcdbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .batch_size (batch_size),
      .req_port   (req_port),
      .rsp_port   (rsp_port),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

endmodule

[rtl/tcdbs_ram.sv]
// simple dual-port synchronous ram, registered read data with read enable
// no dependencies
module tcdbs_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 34
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/tcdbs_csr.sv]
// apb-style register file: batch size register
// depends on tcdbs_pkg
module tcdbs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tcdbs_pkg::ADDR_W-1:0]   paddr,
   input  logic [tcdbs_pkg::DATA_W-1:0]   pwdata,
   output logic [tcdbs_pkg::DATA_W-1:0]   prdata,
   output logic                           pready,
   output logic [tcdbs_pkg::BATCH_W-1:0]  batch_size
);
   import tcdbs_pkg::*;

   logic [BATCH_W-1:0] batch_ff;
   logic [BATCH_W-1:0] batch_in;
   logic               hit;

   assign hit = (paddr[ADDR_W-1] == REG_BATCH_SIZE);

   always_comb begin
      batch_in = batch_ff;
      if (psel && penable && pwrite && hit) begin
         batch_in = pwdata[BATCH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= BATCH_W'(1);
      end else begin
         batch_ff <= batch_in;
      end
   end

   assign prdata     = hit ? DATA_W'(batch_ff) : '0;
   assign pready     = 1'b1;
   assign batch_size = batch_ff;

endmodule

[rtl/tcdbs_ctrl.sv]
// sequencer: duplicate scan, append and class-ordered listing over the entry ram
// depends on tcdbs_pkg, tcdbs_if and the assertion macro header
`include "three_class_dedup_bucket_sort_unit_assert.svh"

module tcdbs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcdbs_pkg::BATCH_W-1:0] batch_size,
   tcdbs_req_if.sink                     req_port,
   tcdbs_rsp_if.source                   rsp_port,
   output tcdbs_pkg::mem_req_type        mem_req,
   input  tcdbs_pkg::entry_type          mem_rdata
);
   import tcdbs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STATUS,
      ST_LIST
   } state_type;

   state_type              state_ff, state_in;
   logic signed [ID_W-1:0] id_ff, id_in;
   logic [CLS_W-1:0]       cls_ff, cls_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       emitted_ff, emitted_in;
   logic                   pend_ff, pend_in;
   logic [CLS_W-1:0]       pass_ff, pass_in;
   logic                   list_ff, list_in;
   kind_type               status_kind_ff, status_kind_in;
   logic                   status_last_ff, status_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic signed [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [CLS_W-1:0]       rsp_cls_ff, rsp_cls_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic [CNT_W-1:0]       count_new;
   logic [CNT_W-1:0]       eff_batch;
   logic                   list_now;
   logic                   last_now;

   // batch size zero acts as one, above capacity saturates
   always_comb begin
      if (batch_size == '0) begin
         eff_batch = CNT_W'(1);
      end else if (BATCH_W'(batch_size) > BATCH_W'(CAPACITY)) begin
         eff_batch = CNT_W'(CAPACITY);
      end else begin
         eff_batch = CNT_W'(batch_size);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign count_new = count_ff + CNT_W'(1);
   assign list_now  = (count_new >= eff_batch);
   assign last_now  = ((emitted_ff + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in       = state_ff;
      id_in          = id_ff;
      cls_in         = cls_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      emitted_in     = emitted_ff;
      pend_in        = pend_ff;
      pass_in        = pass_ff;
      list_in        = list_ff;
      status_kind_in = status_kind_ff;
      status_last_in = status_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_cls_in     = rsp_cls_ff;
      rsp_last_in    = rsp_last_ff;

      mem_req           = '0;
      mem_req.waddr     = count_ff[IDX_W-1:0];
      mem_req.wdata.id  = id_ff;
      mem_req.wdata.cls = cls_ff;
      mem_req.raddr     = idx_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               id_in   = req_port.patient_id;
               cls_in  = req_port.severity;
               idx_in  = '0;
               pend_in = 1'b0;
               if (req_port.severity == CLS_INVALID) begin
                  status_kind_in = KIND_INVALID;
                  status_last_in = 1'b1;
                  list_in        = 1'b0;
                  state_in       = ST_STATUS;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            pend_in = 1'b0;
            if (idx_ff < count_ff) begin
               mem_req.re = 1'b1;
               idx_in     = idx_ff + CNT_W'(1);
               pend_in    = 1'b1;
            end
            if (pend_ff && (mem_rdata.id == id_ff)) begin
               mem_req.re     = 1'b0;
               pend_in        = 1'b0;
               status_kind_in = KIND_DUP;
               status_last_in = 1'b1;
               list_in        = 1'b0;
               state_in       = ST_STATUS;
            end else if (!pend_ff && (idx_ff == count_ff)) begin
               mem_req.we     = 1'b1;
               count_in       = count_new;
               status_kind_in = KIND_ACCEPT;
               status_last_in = !list_now;
               list_in        = list_now;
               state_in       = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = status_kind_ff;
               rsp_id_in    = id_ff;
               rsp_cls_in   = cls_ff;
               rsp_last_in  = status_last_ff;
               if (list_ff) begin
                  pass_in    = CLS_CRITICAL;
                  idx_in     = '0;
                  pend_in    = 1'b0;
                  emitted_in = '0;
                  state_in   = ST_LIST;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LIST: begin
            if (!pend_ff) begin
               if (idx_ff == count_ff) begin
                  pass_in = pass_ff + CLS_W'(1);
                  idx_in  = '0;
               end else begin
                  mem_req.re = 1'b1;
                  idx_in     = idx_ff + CNT_W'(1);
                  pend_in    = 1'b1;
               end
            end else if (mem_rdata.cls != pass_ff) begin
               pend_in = 1'b0;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_LIST;
               rsp_id_in    = mem_rdata.id;
               rsp_cls_in   = mem_rdata.cls;
               rsp_last_in  = last_now;
               emitted_in   = emitted_ff + CNT_W'(1);
               pend_in      = 1'b0;
               if (last_now) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff          <= id_in;
      cls_ff         <= cls_in;
      idx_ff         <= idx_in;
      emitted_ff     <= emitted_in;
      pass_ff        <= pass_in;
      list_ff        <= list_in;
      status_kind_ff <= status_kind_in;
      status_last_ff <= status_last_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_cls_ff     <= rsp_cls_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_port.ready     = (state_ff == ST_IDLE);
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.kind      = rsp_kind_ff;
   assign rsp_port.out_id    = rsp_id_ff;
   assign rsp_port.out_class = rsp_cls_ff;
   assign rsp_port.last      = rsp_last_ff;

   `TCDBS_ASSERT(a_count_below_cap, clock, reset, (state_ff == ST_IDLE) |-> (count_ff < CNT_W'(CAPACITY)))
   `TCDBS_ASSERT(a_no_write_during_read, clock, reset, mem_req.we |-> (!pend_ff && !mem_req.re))
   `TCDBS_ASSERT(a_list_bounded, clock, reset, (state_ff == ST_LIST) |-> (emitted_ff < count_ff))
   `TCDBS_ASSERT(a_take_leaves_idle, clock, reset, (req_port.valid && req_port.ready) |=> (state_ff != ST_IDLE))
   `TCDBS_ASSERT_ALWAYS(a_reset_clears_out, clock, $past(reset) |-> !rsp_valid_ff)

endmodule
